// ===== rtl/core/crtf_pkg.sv =====
package crtf_pkg;

  // marker kind field of a positive marker word (bits 29:28)
  localparam logic [1:0] MARK_IF      = 2'd0;
  localparam logic [1:0] MARK_ELSE_IF = 2'd1;
  localparam logic [1:0] MARK_ELSE    = 2'd2;
  localparam logic [1:0] MARK_ENDIF   = 2'd3;

  // bit positions in the first table word
  localparam int POS_BIT = 31;
  localparam int NEG_BIT = 30;

  // configuration register indexes
  localparam logic [1:0] REG_CUT  = 2'd0;
  localparam logic [1:0] REG_PKG  = 2'd1;
  localparam logic [1:0] REG_INTF = 2'd2;
  localparam logic [1:0] REG_RFE  = 2'd3;

  // value that a zero cut or package register is compared as
  localparam logic [3:0] NIBBLE_ALL = 4'd15;

  // classified table pair
  typedef enum logic [2:0] {
    KIND_PLAIN,
    KIND_COND_HEAD,
    KIND_ELSE,
    KIND_ENDIF,
    KIND_COND_TEST
  } item_kind_t;

  typedef struct packed {
    logic       start;
    item_kind_t kind;
    logic [19:0] cond;
    logic [29:0] addr;
    logic [31:0] data;
  } item_t;

  // chip description from the configuration registers
  typedef struct packed {
    logic [3:0] cut;
    logic [3:0] pkg;
    logic [3:0] intf;
    logic [7:0] rfe;
  } chip_cfg_t;

endpackage

// ===== rtl/core/crtf_front.sv =====
module crtf_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_start,
  input  logic [31:0]     in_first,
  input  logic [31:0]     in_second,
  output logic            f_valid,
  input  logic            f_ready,
  output crtf_pkg::item_t f_item
);
  import crtf_pkg::*;

  logic  f_valid_r;
  item_t f_item_r;
  item_t item_nxt;

  // classify the incoming pair
  always_comb begin
    item_nxt.start = in_start;
    item_nxt.cond  = {in_first[27:24], in_first[15:12], in_first[11:8], in_first[7:0]};
    item_nxt.addr  = in_first[29:0];
    item_nxt.data  = in_second;
    if (in_first[POS_BIT]) begin
      case (in_first[29:28])
        MARK_ENDIF: item_nxt.kind = KIND_ENDIF;
        MARK_ELSE:  item_nxt.kind = KIND_ELSE;
        default:    item_nxt.kind = KIND_COND_HEAD;
      endcase
    end else if (in_first[NEG_BIT]) begin
      item_nxt.kind = KIND_COND_TEST;
    end else begin
      item_nxt.kind = KIND_PLAIN;
    end
  end

  assign in_ready = !f_valid_r || f_ready;

  // input register stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (in_ready) begin
      f_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      f_item_r <= item_nxt;
    end
  end

  assign f_valid = f_valid_r;
  assign f_item  = f_item_r;

endmodule

// ===== rtl/core/crtf_queue.sv =====
module crtf_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            push_ready,
  input  crtf_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop,
  output crtf_pkg::item_t pop_item
);
  import crtf_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push;

  assign push_ready = count_r != CW'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign do_push    = push && push_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH)) else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0) else $error("pop from empty queue");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("push did not grow queue");

endmodule

// ===== rtl/core/crtf_back.sv =====
module crtf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  crtf_pkg::chip_cfg_t cfg,
  input  logic               q_valid,
  output logic               q_pop,
  input  crtf_pkg::item_t    q_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [29:0]        out_addr,
  output logic [31:0]        out_data
);
  import crtf_pkg::*;

  logic        matched_r, matched_nxt;
  logic        taken_r, taken_nxt;
  logic [19:0] held_r, held_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [29:0] out_addr_r, out_addr_nxt;
  logic [31:0] out_data_r, out_data_nxt;

  logic        m0, t0;
  logic [19:0] h0;
  logic [3:0]  cut_eff, pkg_eff;
  logic        cond_ok;

  // pop when the output register is free or being drained
  assign q_pop = q_valid && (!out_valid_r || out_ready);

  // state as it stands after an optional table start
  assign m0 = q_item.start ? 1'b1 : matched_r;
  assign t0 = q_item.start ? 1'b0 : taken_r;
  assign h0 = q_item.start ? '0 : held_r;

  // condition test against the chip description
  assign cut_eff = (cfg.cut == '0) ? NIBBLE_ALL : cfg.cut;
  assign pkg_eff = (cfg.pkg == '0) ? NIBBLE_ALL : cfg.pkg;
  assign cond_ok = (h0[19:16] == '0 || h0[19:16] == cut_eff)
                && (h0[15:12] == '0 || h0[15:12] == pkg_eff)
                && (h0[11:8] == '0 || h0[11:8] == cfg.intf)
                && (h0[7:0] == cfg.rfe);

  // group tracking and write emission
  always_comb begin
    matched_nxt   = matched_r;
    taken_nxt     = taken_r;
    held_nxt      = held_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_addr_nxt  = out_addr_r;
    out_data_nxt  = out_data_r;
    if (q_pop) begin
      matched_nxt = m0;
      taken_nxt   = t0;
      held_nxt    = h0;
      case (q_item.kind)
        KIND_ENDIF: begin
          matched_nxt = 1'b1;
          taken_nxt   = 1'b0;
        end
        KIND_ELSE: begin
          matched_nxt = !t0;
        end
        KIND_COND_HEAD: begin
          held_nxt = q_item.cond;
        end
        KIND_COND_TEST: begin
          if (!t0 && cond_ok) begin
            matched_nxt = 1'b1;
            taken_nxt   = 1'b1;
          end else begin
            matched_nxt = 1'b0;
          end
        end
        KIND_PLAIN: begin
          if (m0) begin
            out_valid_nxt = 1'b1;
            out_addr_nxt  = q_item.addr;
            out_data_nxt  = q_item.data;
          end
        end
        default: begin
          matched_nxt = m0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matched_r   <= 1'b1;
      taken_r     <= 1'b0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      matched_r   <= matched_nxt;
      taken_r     <= taken_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    out_addr_r <= out_addr_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_addr  = out_addr_r;
  assign out_data  = out_data_r;

  a_endif_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_item.kind == KIND_ENDIF) |=> (matched_r && !taken_r))
    else $error("endif did not reopen the group");

  a_skip_unmatched: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_item.kind == KIND_PLAIN && !q_item.start && !matched_r) |=> !out_valid_r)
    else $error("write emitted in unmatched group");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_pop && !(out_valid_r && !out_ready)) |=> !out_valid_r)
    else $error("write appeared without a request");

endmodule

// ===== rtl/core/conditional_register_table_filter.sv =====
// path: an accepted request is registered in the classifier input stage, then in the queue,
// and its write is offered on out_ from the back end output register
// throughput: one table pair per cycle while writes are taken, set by the single-pass
// group tracker in the back end; a four-deep queue before the tracker absorbs output stalls
// reset: rst_n is synchronous and active low; it clears the queue, output and group
// flags (group matched, nothing taken, held condition zero) and all config registers
module conditional_register_table_filter #(
  parameter int DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // input table pairs
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // first_word[31:0], second_word[63:32]
  input  logic        in_tuser,   // table_start
  // register writes
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // reg_addr[29:0], reg_data[61:30], zero[63:62]
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import crtf_pkg::*;

  logic [3:0] cut_r;
  logic [3:0] pkg_r;
  logic [3:0] intf_r;
  logic [7:0] rfe_r;
  chip_cfg_t  cfg;
  logic       cfg_wr;

  logic       f_valid, f_ready;
  item_t      f_item;
  logic       q_valid, q_pop;
  item_t      q_item;
  logic [29:0] out_addr;
  logic [31:0] out_data;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cut_r  <= '0;
      pkg_r  <= '0;
      intf_r <= '0;
      rfe_r  <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_CUT:  cut_r  <= cfg_pwdata[3:0];
        REG_PKG:  pkg_r  <= cfg_pwdata[3:0];
        REG_INTF: intf_r <= cfg_pwdata[3:0];
        REG_RFE:  rfe_r  <= cfg_pwdata[7:0];
        default:  rfe_r  <= rfe_r;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_paddr[3:2])
      REG_CUT:  cfg_prdata = {28'd0, cut_r};
      REG_PKG:  cfg_prdata = {28'd0, pkg_r};
      REG_INTF: cfg_prdata = {28'd0, intf_r};
      REG_RFE:  cfg_prdata = {24'd0, rfe_r};
      default:  cfg_prdata = '0;
    endcase
  end

  assign cfg.cut  = cut_r;
  assign cfg.pkg  = pkg_r;
  assign cfg.intf = intf_r;
  assign cfg.rfe  = rfe_r;

  // classifier
  crtf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_start  (in_tuser),
    .in_first  (in_tdata[31:0]),
    .in_second (in_tdata[63:32]),
    .f_valid   (f_valid),
    .f_ready   (f_ready),
    .f_item    (f_item)
  );

  // decoupling queue
  crtf_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  // group tracker and write output
  crtf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_addr  (out_addr),
    .out_data  (out_data)
  );

  assign out_tdata = {2'b00, out_data, out_addr};

endmodule

// ===== test/conditional_register_table_filter_tb.sv =====
`timescale 1ns / 100ps

module conditional_register_table_filter_tb;
  import crtf_pkg::*;

  // one table pair as offered on the input stream
  typedef struct packed {
    logic        start;
    logic [31:0] first;
    logic [31:0] second;
  } table_pair_t;

  // one register write as expected on the output stream
  typedef struct packed {
    logic [29:0] addr;
    logic [31:0] data;
  } reg_write_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // first_word[31:0], second_word[63:32]
  logic        in_tuser = 1'b0; // table_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // reg_addr[29:0], reg_data[61:30], zero[63:62]
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // pending requests, expected writes and run bookkeeping
  table_pair_t pending_pairs[$];
  reg_write_t  writes_due[$];
  int          pairs_queued = 0;
  int          pairs_taken = 0;
  int          writes_seen = 0;
  int          settings_used = 0;
  int          fail_count = 0;
  logic        req_taken = 1'b0;
  logic        calm = 1'b0;
  int          hold_left = 0;
  int          holds_done = 0;

  // chip description and group tracker of the predictor
  chip_cfg_t   chip = '0;
  logic        grp_matched = 1'b1;
  logic        grp_taken = 1'b0;
  logic [19:0] held_cond = '0;

  conditional_register_table_filter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // does the held condition fit the configured chip
  function automatic logic chip_matches(input logic [19:0] cond);
    logic [3:0] cut_eff;
    logic [3:0] pkg_eff;
    cut_eff = (chip.cut == 4'd0) ? NIBBLE_ALL : chip.cut;
    pkg_eff = (chip.pkg == 4'd0) ? NIBBLE_ALL : chip.pkg;
    return (cond[19:16] == 4'd0 || cond[19:16] == cut_eff) &&
           (cond[15:12] == 4'd0 || cond[15:12] == pkg_eff) &&
           (cond[11:8] == 4'd0 || cond[11:8] == chip.intf) &&
           (cond[7:0] == chip.rfe);
  endfunction

  // group tracker: updates flags and records the write a plain pair causes
  function automatic void filter_pair(input logic start, input logic [31:0] w1,
                                      input logic [31:0] w2);
    if (start) begin
      grp_matched = 1'b1;
      grp_taken = 1'b0;
      held_cond = '0;
    end
    if (w1[POS_BIT]) begin
      case (w1[29:28])
        MARK_ENDIF: begin
          grp_matched = 1'b1;
          grp_taken = 1'b0;
        end
        MARK_ELSE: grp_matched = !grp_taken;
        default: held_cond = {w1[27:24], w1[15:12], w1[11:8], w1[7:0]};
      endcase
    end else if (w1[NEG_BIT]) begin
      if (!grp_taken && chip_matches(held_cond)) begin
        grp_matched = 1'b1;
        grp_taken = 1'b1;
      end else begin
        grp_matched = 1'b0;
      end
    end else if (grp_matched) begin
      writes_due.push_back('{w1[29:0], w2});
    end
  endfunction

  // predictor and output checker
  always @(posedge clk) begin
    reg_write_t want;
    logic [29:0] got_addr;
    logic [31:0] got_data;
    req_taken <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      filter_pair(in_tuser, in_tdata[31:0], in_tdata[63:32]);
      pairs_taken++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got_addr = out_tdata[29:0];
      got_data = out_tdata[61:30];
      writes_seen++;
      if (writes_due.size() == 0) begin
        $display("%0t: unexpected write, expected none, got addr %h data %h",
                 $time, got_addr, got_data);
        fail_count++;
      end else begin
        want = writes_due.pop_front();
        if (got_addr != want.addr) begin
          $display("%0t: reg_addr expected %h got %h", $time, want.addr, got_addr);
          fail_count++;
        end
        if (got_data != want.data) begin
          $display("%0t: reg_data expected %h got %h", $time, want.data, got_data);
          fail_count++;
        end
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    table_pair_t pair;
    if (rst_n && (!in_tvalid || req_taken)) begin
      if (pending_pairs.size() != 0 && (calm || $urandom_range(99) >= 36)) begin
        pair = pending_pairs.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {pair.second, pair.first};
        in_tuser <= pair.start;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // write receiver with random stalls and two long hold-offs
  always @(negedge clk) begin
    if (holds_done < 2 && pairs_taken >= 400 + 600 * holds_done) begin
      hold_left = 150;
      holds_done++;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 36);
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("[conditional_register_table_filter] ERROR");
    $finish;
  end

  task automatic queue_pair(input logic start, input logic [31:0] w1, input logic [31:0] w2);
    pending_pairs.push_back('{start, w1, w2});
    pairs_queued++;
  endtask

  // register write over the config port, ending on an idle cycle
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_CUT:  chip.cut = val[3:0];
      REG_PKG:  chip.pkg = val[3:0];
      REG_INTF: chip.intf = val[3:0];
      default:  chip.rfe = val[7:0];
    endcase
    @(negedge clk);
  endtask

  task automatic set_chip(input logic [3:0] cut, input logic [3:0] pkg,
                          input logic [3:0] intf, input logic [7:0] rfe);
    write_reg(REG_CUT, {28'($urandom), cut});
    write_reg(REG_PKG, {28'($urandom), pkg});
    write_reg(REG_INTF, {28'($urandom), intf});
    write_reg(REG_RFE, {24'($urandom), rfe});
    settings_used++;
  endtask

  // wait until every request is taken and every write seen, then let markers settle
  task automatic drain();
    while (pairs_taken != pairs_queued || writes_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [31:0] cond_word(input logic [1:0] kind, input logic [3:0] c,
                                            input logic [3:0] p, input logic [3:0] i,
                                            input logic [7:0] r);
    return {1'b1, 1'b0, kind, c, 8'h00, p, i, r};
  endfunction

  function automatic logic [31:0] plain_word();
    logic [31:0] w;
    w = $urandom;
    w[31:30] = 2'b00;
    return w;
  endfunction

  function automatic logic [31:0] test_word();
    logic [31:0] w;
    w = $urandom;
    w[POS_BIT] = 1'b0;
    w[NEG_BIT] = 1'b1;
    return w;
  endfunction

  function automatic logic [31:0] mark_word(input logic [1:0] kind);
    logic [31:0] w;
    w = $urandom;
    w[POS_BIT] = 1'b1;
    w[29:28] = kind;
    return w;
  endfunction

  // condition nibble: wildcard, the chip's own value, or anything
  function automatic logic [3:0] cond_nibble(input logic [3:0] eff);
    int r;
    r = $urandom_range(9);
    if (r < 4) return 4'd0;
    if (r < 8) return eff;
    return 4'($urandom);
  endfunction

  // IF or ELSE_IF head biased toward the current chip, with random side bits
  function automatic logic [31:0] head_word(input logic [1:0] kind);
    logic [31:0] w;
    w = cond_word(kind,
                  cond_nibble(chip.cut == 4'd0 ? NIBBLE_ALL : chip.cut),
                  cond_nibble(chip.pkg == 4'd0 ? NIBBLE_ALL : chip.pkg),
                  cond_nibble(chip.intf),
                  ($urandom_range(99) < 75) ? chip.rfe : 8'($urandom));
    w[NEG_BIT] = 1'($urandom_range(1));
    w[23:16] = 8'($urandom);
    return w;
  endfunction

  task automatic queue_plains(input int lo, input int hi);
    repeat ($urandom_range(hi, lo)) queue_pair(1'b0, plain_word(), $urandom);
  endtask

  // one well-formed conditional group with random content
  task automatic queue_group();
    queue_pair($urandom_range(9) == 0, head_word(MARK_IF), $urandom);
    queue_pair(1'b0, test_word(), $urandom);
    queue_plains(1, 4);
    repeat ($urandom_range(2)) begin
      queue_pair(1'b0, head_word(MARK_ELSE_IF), $urandom);
      queue_pair(1'b0, test_word(), $urandom);
      queue_plains(1, 4);
    end
    if ($urandom_range(1)) begin
      queue_pair(1'b0, mark_word(MARK_ELSE), $urandom);
      queue_plains(1, 4);
    end
    queue_pair(1'b0, mark_word(MARK_ENDIF), $urandom);
    queue_plains(0, 3);
  endtask

  // stray words: anything at all, lone markers, lone tests or plain pairs
  task automatic queue_noise();
    case ($urandom_range(3))
      0: queue_pair($urandom_range(3) == 0, $urandom, $urandom);
      1: queue_pair($urandom_range(5) == 0, mark_word(2'($urandom)), $urandom);
      2: queue_pair(1'b0, test_word(), $urandom);
      default: queue_pair($urandom_range(5) == 0, plain_word(), $urandom);
    endcase
  endtask

  // stimulus
  initial begin
    int goal;
    logic [31:0] both_marks;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table under the reset chip: cut and package compare as 15, rest zero
    queue_pair(1'b1, 32'h3FFF_FFFF, 32'hFFFF_FFFF);
    queue_pair(1'b0, 32'h0000_0000, 32'h0000_0000);
    // test with no head compares a zero held condition
    queue_pair(1'b0, test_word(), $urandom);
    queue_pair(1'b0, plain_word(), $urandom);
    // test again while a branch is taken closes the group
    queue_pair(1'b0, test_word(), $urandom);
    queue_pair(1'b0, plain_word(), $urandom);
    queue_pair(1'b0, mark_word(MARK_ELSE), $urandom);
    queue_pair(1'b0, plain_word(), $urandom);
    queue_pair(1'b0, mark_word(MARK_ENDIF), $urandom);
    queue_pair(1'b0, plain_word(), $urandom);
    // cut mismatch, then an else-if that fits, then a late else-if and else
    queue_pair(1'b0, cond_word(MARK_IF, 4'd3, 4'd0, 4'd0, 8'd0), $urandom);
    queue_pair(1'b0, test_word(), $urandom);
    queue_pair(1'b0, plain_word(), $urandom);
    queue_pair(1'b0, cond_word(MARK_ELSE_IF, 4'd15, 4'd15, 4'd0, 8'd0), $urandom);
    queue_pair(1'b0, test_word(), $urandom);
    queue_pair(1'b0, plain_word(), $urandom);
    queue_pair(1'b0, cond_word(MARK_ELSE_IF, 4'd0, 4'd0, 4'd0, 8'd0), $urandom);
    queue_pair(1'b0, test_word(), $urandom);
    queue_pair(1'b0, mark_word(MARK_ELSE), $urandom);
    queue_pair(1'b0, plain_word(), $urandom);
    // rfe mismatch, then a table start reopens output
    queue_pair(1'b0, cond_word(MARK_IF, 4'd0, 4'd0, 4'd0, 8'd5), $urandom);
    queue_pair(1'b0, test_word(), $urandom);
    queue_pair(1'b1, plain_word(), $urandom);
    // head with both marker bits set and an interface mismatch
    both_marks = cond_word(MARK_IF, 4'd0, 4'd0, 4'hF, 8'd0) | 32'h40FF_0000;
    queue_pair(1'b0, both_marks, 32'hFFFF_FFFF);
    queue_pair(1'b0, test_word(), $urandom);
    queue_pair(1'b0, plain_word(), $urandom);
    drain();

    // random tables under several chip settings, extremes first
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_chip(4'd0, 4'd0, 4'd0, 8'd0);
        1: set_chip(4'd15, 4'd15, 4'd15, 8'd255);
        default: set_chip(4'($urandom), 4'($urandom), 4'($urandom), 8'($urandom));
      endcase
      @(posedge clk);
      calm = (ph == 2);
      goal = pairs_queued + 178;
      while (pairs_queued < goal) begin
        if ($urandom_range(99) < 80) queue_group();
        else queue_noise();
      end
      drain();
      calm = 1'b0;
    end

    $display("ran %0d table pairs under %0d chip settings, %0d register writes checked",
             pairs_taken, settings_used, writes_seen);
    if (fail_count == 0) begin
      $display("[conditional_register_table_filter] OK");
    end else begin
      $display("[conditional_register_table_filter] ERROR");
    end
    $finish;
  end

endmodule
